// ===== src/oas_pkg.sv =====
// oas_pkg: shared constants for the obstacle avoidance sequencer
// register indexes, motion codes and widths; no dependencies

package oas_pkg;

    localparam int unsigned DIST_W   = 16;
    localparam int unsigned THR_W    = 13;
    localparam int unsigned TCK_W    = 8;
    localparam int unsigned CNT_W    = 9;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 13;

    localparam logic [CNT_W-1:0] TICK_MAX = 9'd511;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAUTION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOO_CLOSE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLEARANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TURN      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 3'd6;

    // linear motion codes
    localparam logic [1:0] LIN_STOP    = 2'd0;
    localparam logic [1:0] LIN_FORWARD = 2'd1;
    localparam logic [1:0] LIN_REVERSE = 2'd2;

    // angular motion codes
    localparam logic [1:0] ANG_NONE  = 2'd0;
    localparam logic [1:0] ANG_LEFT  = 2'd1;
    localparam logic [1:0] ANG_RIGHT = 2'd2;

    // reset values of the configuration registers
    localparam logic [THR_W-1:0] RST_CAUTION   = 13'd1000;
    localparam logic [THR_W-1:0] RST_STOP      = 13'd500;
    localparam logic [THR_W-1:0] RST_TOO_CLOSE = 13'd250;
    localparam logic [THR_W-1:0] RST_CLEARANCE = 13'd750;
    localparam logic [TCK_W-1:0] RST_REVERSE   = 8'd16;
    localparam logic [TCK_W-1:0] RST_TURN      = 8'd13;
    localparam logic [TCK_W-1:0] RST_SETTLE    = 8'd7;

endpackage

// ===== src/obstacle_avoid_sequencer_top.sv =====
// obstacle_avoid_sequencer_top: eleven-mode obstacle avoidance sequencer
// depends on oas_pkg for register indexes, motion codes and widths
//
// usage:
//   s_axis carries one control tick per transaction: tuser is the depth
//   freshness flag, tdata the four depth readings in mm (65535 = no reading).
//   m_axis returns exactly one result per tick: linear and angular motion
//   codes and the mode after the tick.
//   the config port writes one threshold or tick count per cycle when
//   i_cfg_wr_en is high; write it only while no tick is in flight.
// timing:
//   the whole mode update is one combinational pass from the accepted tick
//   and the mode state into the result register, so a result appears in the
//   cycle after its tick; one tick is taken every cycle while not stalled.
//   s_axis_tready is high while the result register is empty or being taken;
//   when the receiver stalls, the result holds and new ticks wait.
// reset:
//   i_rst_n low (synchronous) returns the mode to drive, clears the mode
//   tick counter and scans, selects a left avoid turn and loads the default
//   thresholds and tick counts; the result register is emptied.

module obstacle_avoid_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // center_mm, left_mm, right_mm, scan_mm
    input  logic        s_axis_tuser,  // depth_fresh
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // linear_cmd, angular_cmd, mode_now
    // configuration
    input  logic                             i_cfg_wr_en,
    input  logic [oas_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [oas_pkg::CFG_DAT_W-1:0]    i_cfg_data
);

    typedef enum logic [3:0] {
        DRIVE            = 4'd0,
        PRE_SCAN_HALT    = 4'd1,
        SCAN_LEFT_TURN   = 4'd2,
        SCAN_LEFT_HOLD   = 4'd3,
        SCAN_RIGHT_TURN  = 4'd4,
        SCAN_RIGHT_HOLD  = 4'd5,
        CENTER_TURN      = 4'd6,
        CENTER_HOLD      = 4'd7,
        REVERSE          = 4'd8,
        DODGE_TURN       = 4'd9,
        BLOCKED          = 4'd10
    } t_mode;

    // configuration registers
    logic [oas_pkg::THR_W-1:0] r_caution, r_stop, r_too_close, r_clearance;
    logic [oas_pkg::TCK_W-1:0] r_reverse, r_turn, r_settle;

    // mode state
    t_mode                      r_mode, n_mode;
    logic [oas_pkg::CNT_W-1:0]  r_ticks, n_ticks;
    logic [oas_pkg::DIST_W-1:0] r_left_scan, n_left_scan;
    logic [oas_pkg::DIST_W-1:0] r_right_scan, n_right_scan;
    logic                       r_turn_left, n_turn_left;

    // result register
    logic       r_out_valid;
    logic [1:0] r_lin, n_lin;
    logic [1:0] r_ang, n_ang;
    logic [3:0] r_mode_out;

    logic                       in_fire;
    logic                       fresh;
    logic [oas_pkg::DIST_W-1:0] center, left, right, scan;
    logic [oas_pkg::CNT_W-1:0]  t;
    logic [oas_pkg::CNT_W-1:0]  settle_x, turn_x, turn2_x, reverse_x;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign fresh  = s_axis_tuser;
    assign center = s_axis_tdata[15:0];
    assign left   = s_axis_tdata[31:16];
    assign right  = s_axis_tdata[47:32];
    assign scan   = s_axis_tdata[63:48];

    assign t         = (r_ticks < oas_pkg::TICK_MAX) ? r_ticks + 9'd1 : r_ticks;
    assign settle_x  = {1'b0, r_settle};
    assign turn_x    = {1'b0, r_turn};
    assign turn2_x   = {r_turn, 1'b0};
    assign reverse_x = {1'b0, r_reverse};

    always_comb begin
        n_mode       = r_mode;
        n_ticks      = t;
        n_left_scan  = r_left_scan;
        n_right_scan = r_right_scan;
        n_turn_left  = r_turn_left;
        n_lin        = oas_pkg::LIN_STOP;
        n_ang        = oas_pkg::ANG_NONE;
        if (fresh) begin
            case (r_mode)
                DRIVE: begin
                    if (center <= {3'b000, r_too_close}) begin
                        n_mode = PRE_SCAN_HALT;
                    end else if (center <= {3'b000, r_stop}) begin
                        n_turn_left = (left >= right);
                        n_mode      = DODGE_TURN;
                    end else begin
                        n_lin = oas_pkg::LIN_FORWARD;
                    end
                end
                PRE_SCAN_HALT: begin
                    if (t >= settle_x) n_mode = SCAN_LEFT_TURN;
                end
                SCAN_LEFT_TURN: begin
                    if (t >= turn_x) n_mode = SCAN_LEFT_HOLD;
                    else n_ang = oas_pkg::ANG_LEFT;
                end
                SCAN_LEFT_HOLD: begin
                    if (t >= settle_x) begin
                        n_left_scan = scan;
                        n_mode      = SCAN_RIGHT_TURN;
                    end
                end
                SCAN_RIGHT_TURN: begin
                    if (t >= turn2_x) n_mode = SCAN_RIGHT_HOLD;
                    else n_ang = oas_pkg::ANG_RIGHT;
                end
                SCAN_RIGHT_HOLD: begin
                    if (t >= settle_x) begin
                        n_right_scan = scan;
                        n_mode       = CENTER_TURN;
                    end
                end
                CENTER_TURN: begin
                    if (t >= turn_x) n_mode = CENTER_HOLD;
                    else n_ang = oas_pkg::ANG_LEFT;
                end
                CENTER_HOLD: begin
                    if (t >= settle_x) begin
                        if (r_left_scan >= {3'b000, r_clearance} &&
                            r_right_scan >= {3'b000, r_clearance}) begin
                            n_mode = REVERSE;
                        end else begin
                            n_mode = BLOCKED;
                        end
                    end
                end
                REVERSE: begin
                    if (t >= reverse_x) begin
                        n_turn_left = (r_left_scan >= r_right_scan);
                        n_mode      = DODGE_TURN;
                    end else begin
                        n_lin = oas_pkg::LIN_REVERSE;
                    end
                end
                DODGE_TURN: begin
                    if (t >= turn_x) n_mode = DRIVE;
                    else n_ang = r_turn_left ? oas_pkg::ANG_LEFT : oas_pkg::ANG_RIGHT;
                end
                BLOCKED: begin
                    if (center > {3'b000, r_caution}) n_mode = DRIVE;
                end
                default: begin
                    n_mode = DRIVE;
                end
            endcase
            // entering a mode restarts its tick count
            if (n_mode != r_mode || r_mode > BLOCKED) n_ticks = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caution    <= oas_pkg::RST_CAUTION;
            r_stop       <= oas_pkg::RST_STOP;
            r_too_close  <= oas_pkg::RST_TOO_CLOSE;
            r_clearance  <= oas_pkg::RST_CLEARANCE;
            r_reverse    <= oas_pkg::RST_REVERSE;
            r_turn       <= oas_pkg::RST_TURN;
            r_settle     <= oas_pkg::RST_SETTLE;
            r_mode       <= DRIVE;
            r_ticks      <= '0;
            r_left_scan  <= '0;
            r_right_scan <= '0;
            r_turn_left  <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    oas_pkg::REG_CAUTION:   r_caution   <= i_cfg_data;
                    oas_pkg::REG_STOP:      r_stop      <= i_cfg_data;
                    oas_pkg::REG_TOO_CLOSE: r_too_close <= i_cfg_data;
                    oas_pkg::REG_CLEARANCE: r_clearance <= i_cfg_data;
                    oas_pkg::REG_REVERSE:   r_reverse   <= i_cfg_data[oas_pkg::TCK_W-1:0];
                    oas_pkg::REG_TURN:      r_turn      <= i_cfg_data[oas_pkg::TCK_W-1:0];
                    oas_pkg::REG_SETTLE:    r_settle    <= i_cfg_data[oas_pkg::TCK_W-1:0];
                    default: ;
                endcase
            end
            if (in_fire) begin
                r_mode       <= n_mode;
                r_ticks      <= n_ticks;
                r_left_scan  <= n_left_scan;
                r_right_scan <= n_right_scan;
                r_turn_left  <= n_turn_left;
                r_out_valid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
        if (in_fire) begin
            r_lin      <= n_lin;
            r_ang      <= n_ang;
            r_mode_out <= n_mode;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_mode_out, r_ang, r_lin};

    // never drive and turn in the same result
    a_no_drive_and_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == oas_pkg::LIN_STOP ||
                           m_axis_tdata[3:2] == oas_pkg::ANG_NONE))
        else $error("linear and angular motion in one result");

    // stale depth gives stop and keeps the mode
    a_stale_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !s_axis_tuser) |=>
            (m_axis_tdata[3:0] == 4'd0 && m_axis_tdata[7:4] == $past(r_mode)))
        else $error("stale tick did not stop or changed mode");

    // reverse motion only while in reverse mode
    a_reverse_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] == oas_pkg::LIN_REVERSE) |->
            (m_axis_tdata[7:4] == REVERSE))
        else $error("reverse motion outside reverse mode");

endmodule
